>>> design/bpa_pkg.sv
// Shared types, constants and control structs of the bitmap page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int DEF_TOTAL_PAGES   = 32768;
    localparam int DEF_MAP_WORD_BITS = 32;

    localparam int REGION_W   = 64;
    localparam int TYPE_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_NUM_W = REGION_W - PAGE_SHIFT;
    localparam int ADDR_W     = 27;
    localparam int PROT_W     = 16;
    localparam int OPC_W      = 2;

    localparam logic [PROT_W-1:0] PROT_RESET  = 16'd256;
    localparam logic [TYPE_W-1:0] USABLE_TYPE = 32'd1;

    localparam logic [OPC_W-1:0] OP_FILL  = 2'd0;
    localparam logic [OPC_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OPC_W-1:0] OP_ALLOC = 2'd2;

    typedef struct packed {
        logic [OPC_W-1:0]    opcode;
        logic [REGION_W-1:0] region_base;
        logic [REGION_W-1:0] region_length;
        logic [TYPE_W-1:0]   region_type;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic              alloc_ok;
    } t_out_item;

    typedef struct packed {
        logic load_item;
        logic cnt_clr;
        logic cnt_inc;
        logic rd_en;
        logic range_calc;
        logic wr_fill;
        logic wr_free;
        logic found_latch;
        logic wr_alloc;
        logic out_ok;
        logic out_fail;
    } t_dp_cmd;

    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             usable;
        logic             range_empty;
        logic             walk_end;
        logic             cnt_last;
        logic             word_full;
        logic             out_free;
    } t_dp_sts;

endpackage

>>> design/bpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/bpa_dp.sv
// Datapath: item and range registers, word counter, map RAM, bit search and result register.
`timescale 1ns / 1ps

module bpa_dp #(
    parameter int TOTAL_PAGES   = bpa_pkg::DEF_TOTAL_PAGES,
    parameter int MAP_WORD_BITS = bpa_pkg::DEF_MAP_WORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpa_pkg::t_in_item             i_in_item,
    input  logic                          i_cfg_we,
    input  logic [bpa_pkg::PROT_W-1:0]    i_cfg_wdata,
    input  bpa_pkg::t_dp_cmd              i_cmd,
    output bpa_pkg::t_dp_sts              o_sts,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output bpa_pkg::t_out_item            o_out_item
);
    import bpa_pkg::*;

    localparam int MAP_WORDS = (TOTAL_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int PCW       = $clog2(TOTAL_PAGES + 1);
    localparam int BASE_W    = $clog2(MAP_WORDS * MAP_WORD_BITS + 1);
    localparam int FIRST_W   = (PCW > PROT_W) ? PCW : PROT_W;
    localparam int CW        = ((FIRST_W > BASE_W) ? FIRST_W : BASE_W) + 1;

    t_in_item                 r_item;
    logic [PROT_W-1:0]        r_prot;
    logic [FIRST_W-1:0]       r_first;
    logic [PCW-1:0]           r_last;
    logic                     r_base_hi;
    logic [WA_W-1:0]          r_cnt;
    logic [WA_W-1:0]          n_cnt;
    logic [BASE_W-1:0]        r_base;
    logic [BASE_W-1:0]        n_base;
    logic [MAP_WORD_BITS-1:0] r_wword;
    logic [BIT_W-1:0]         r_bit;
    logic                     r_out_valid;
    t_out_item                r_out_item;

    logic [MAP_WORD_BITS-1:0] ram_rdata;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic                     ram_we;

    logic [PAGE_NUM_W-1:0]    base_pg;
    logic [PAGE_NUM_W-1:0]    len_pg;
    logic [PAGE_NUM_W:0]      end_pg;
    logic [PCW-1:0]           last_c;
    logic [FIRST_W-1:0]       base_lo;
    logic [FIRST_W-1:0]       prot_ext;
    logic [FIRST_W-1:0]       first_c;

    logic signed [CW-1:0]     d_lo;
    logic signed [CW-1:0]     d_hi;
    logic [MAP_WORD_BITS-1:0] clr_mask;
    logic [BIT_W-1:0]         low_idx;
    logic [BASE_W-1:0]        page_num;
    logic [BASE_W:0]          next_base;

    // Region bounds in pages, clipped to the map and the protected floor
    always_comb begin
        base_pg  = r_item.region_base[REGION_W-1:PAGE_SHIFT];
        len_pg   = r_item.region_length[REGION_W-1:PAGE_SHIFT];
        end_pg   = {1'b0, base_pg} + {1'b0, len_pg};
        last_c   = (end_pg > (PAGE_NUM_W+1)'(TOTAL_PAGES)) ? PCW'(TOTAL_PAGES)
                                                           : end_pg[PCW-1:0];
        base_lo  = FIRST_W'(base_pg);
        prot_ext = FIRST_W'(r_prot);
        first_c  = (base_lo > prot_ext) ? base_lo : prot_ext;
    end

    // Word counter and page number of bit 0 of the current word
    always_comb begin
        n_cnt  = r_cnt;
        n_base = r_base;
        if (i_cmd.cnt_clr) begin
            n_cnt  = '0;
            n_base = '0;
        end else if (i_cmd.cnt_inc) begin
            n_cnt  = r_cnt + WA_W'(1);
            n_base = r_base + BASE_W'(MAP_WORD_BITS);
        end
    end

    // Bits of the current word that fall inside the region
    always_comb begin
        d_lo     = $signed(CW'(r_first)) - $signed(CW'(r_base));
        d_hi     = $signed(CW'(r_last)) - $signed(CW'(r_base));
        clr_mask = '0;
        for (int b = 0; b < MAP_WORD_BITS; b++) begin
            if (($signed(CW'(b)) >= d_lo) && ($signed(CW'(b)) < d_hi)) begin
                clr_mask[b] = 1'b1;
            end
        end
    end

    // Lowest clear bit of the word just read
    always_comb begin
        low_idx = '0;
        for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
            if (!ram_rdata[b]) begin
                low_idx = BIT_W'(b);
            end
        end
    end

    always_comb begin
        ram_we = i_cmd.wr_fill | i_cmd.wr_free | i_cmd.wr_alloc;
        if (i_cmd.wr_fill) begin
            ram_wdata = '1;
        end else if (i_cmd.wr_free) begin
            ram_wdata = ram_rdata & ~clr_mask;
        end else begin
            ram_wdata = r_wword;
        end
    end

    assign page_num  = r_base + BASE_W'(r_bit);
    assign next_base = {1'b0, r_base} + (BASE_W+1)'(MAP_WORD_BITS);

    bpa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (WA_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (n_cnt),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prot      <= PROT_RESET;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_base      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_prot <= i_cfg_wdata;
            end
            r_cnt  <= n_cnt;
            r_base <= n_base;
            if (i_cmd.out_ok || i_cmd.out_fail) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.range_calc) begin
            r_first   <= first_c;
            r_last    <= last_c;
            r_base_hi <= (base_pg >= PAGE_NUM_W'(TOTAL_PAGES));
        end
        if (i_cmd.found_latch) begin
            r_wword <= ram_rdata | (ram_rdata + MAP_WORD_BITS'(1));
            r_bit   <= low_idx;
        end
        if (i_cmd.out_ok) begin
            r_out_item.page_address <= ADDR_W'({page_num, {PAGE_SHIFT{1'b0}}});
            r_out_item.alloc_ok     <= 1'b1;
        end else if (i_cmd.out_fail) begin
            r_out_item <= '0;
        end
    end

    always_comb begin
        o_sts.op          = r_item.opcode;
        o_sts.usable      = (r_item.region_type == USABLE_TYPE);
        o_sts.range_empty = r_base_hi || (r_first >= FIRST_W'(r_last));
        o_sts.walk_end    = (next_base >= (BASE_W+1)'(r_last));
        o_sts.cnt_last    = (r_cnt == WA_W'(MAP_WORDS - 1));
        o_sts.word_full   = &ram_rdata;
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> design/bpa_ctrl.sv
// Controller: sequences fill, region free and allocate over the datapath.
`timescale 1ns / 1ps

module bpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  bpa_pkg::t_dp_sts i_sts,
    output bpa_pkg::t_dp_cmd o_cmd
);
    import bpa_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_FREE_CHK  = 3'd2;
    localparam logic [2:0] S_FREE_WALK = 3'd3;
    localparam logic [2:0] S_FILL      = 3'd4;
    localparam logic [2:0] S_SCAN      = 3'd5;
    localparam logic [2:0] S_ALLOC_WR  = 3'd6;
    localparam logic [2:0] S_FAIL_WR   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_FILL: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_FILL;
                    end
                    OP_FREE: begin
                        o_cmd.range_calc = 1'b1;
                        n_state          = S_FREE_CHK;
                    end
                    OP_ALLOC: begin
                        o_cmd.cnt_clr = 1'b1;
                        o_cmd.rd_en   = 1'b1;
                        n_state       = S_SCAN;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FREE_CHK: begin
                if (!i_sts.usable || i_sts.range_empty) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.cnt_clr = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    n_state       = S_FREE_WALK;
                end
            end
            S_FREE_WALK: begin
                o_cmd.wr_free = 1'b1;
                if (i_sts.walk_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                end
            end
            S_FILL: begin
                o_cmd.wr_fill = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_SCAN: begin
                if (!i_sts.word_full) begin
                    o_cmd.found_latch = 1'b1;
                    n_state           = S_ALLOC_WR;
                end else if (i_sts.cnt_last) begin
                    n_state = S_FAIL_WR;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                end
            end
            S_ALLOC_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_alloc = 1'b1;
                    o_cmd.out_ok   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FAIL_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_fail = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> design/bitmap_page_allocator.sv
// Top level of the first-fit bitmap physical page allocator.
`timescale 1ns / 1ps

//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_stall      i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_stall    o_out_item (t_out_item)
//  cfg       input      i_cfg_we                     i_cfg_wdata (protected page count)
//
//  One item is worked on at a time; the map RAM is swept one word per cycle.
//  Fill writes every map word. Free walks from word 0 up to the word holding
//  the region's last page. Allocate scans the words (MAP_WORDS at most) until
//  the first word with a clear bit.
//  Reset sets the protected count to 256; the map is undefined until a fill.
//  A finished result waits in the output register while the next item starts;
//  a second allocate result holds in the controller until that register empties.

module bitmap_page_allocator #(
    parameter int TOTAL_PAGES   = bpa_pkg::DEF_TOTAL_PAGES,
    parameter int MAP_WORD_BITS = bpa_pkg::DEF_MAP_WORD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  bpa_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output bpa_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_we,
    input  logic [bpa_pkg::PROT_W-1:0] i_cfg_wdata
);
    import bpa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: accepts an item only when idle and steps through its sweep
    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Map storage, region bounds, bit search and the result register
    bpa_dp #(
        .TOTAL_PAGES   (TOTAL_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

>>> sim/testbench.sv
// Self-checking testbench of the bitmap page allocator, scored against a bit-level page map.
`timescale 1ns / 1ps

module testbench;
    import bpa_pkg::*;

    localparam int TOTAL_PAGES    = DEF_TOTAL_PAGES;
    localparam int WORD_BITS      = DEF_MAP_WORD_BITS;
    localparam int MAP_WORDS      = TOTAL_PAGES / WORD_BITS;
    // A fill or a full-map free walk sweeps every map word with no answer.
    localparam int DRAIN_CYCLES   = MAP_WORDS + 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int TARGET_ITEMS   = 580;
    localparam int ROUND_ITEMS    = 40;
    localparam int MAX_REPORTS    = 10;
    // The one opcode the block leaves alone.
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    // Map model: one bit per page, set means used or reserved. It also holds the
    // queue of allocate answers that the block still owes.
    class alloc_scoreboard;
        bit [WORD_BITS-1:0] map_words [MAP_WORDS];
        logic [PROT_W-1:0]  protected_pages;
        t_out_item          owed_answers [$];
        int                 mismatches;
        int                 answers;
        int                 taken;
        int                 map_full;

        function new();
            protected_pages = PROT_RESET;
        endfunction

        function void set_protected(logic [PROT_W-1:0] count);
            protected_pages = count;
        endfunction

        function void note_item(t_in_item it);
            logic [REGION_W-1:0] first_page;
            logic [REGION_W-1:0] end_page;
            logic [REGION_W-1:0] page;
            t_out_item           answer;
            int                  w;
            int                  b;
            case (it.opcode)
                OP_FILL: begin
                    foreach (map_words[i]) map_words[i] = '1;
                end
                OP_FREE: begin
                    if (it.region_type == USABLE_TYPE) begin
                        // Truncate to whole pages, then clip to the protected floor and map end.
                        first_page = it.region_base >> PAGE_SHIFT;
                        end_page   = first_page + (it.region_length >> PAGE_SHIFT);
                        if (first_page < REGION_W'(protected_pages))
                            first_page = REGION_W'(protected_pages);
                        if (end_page > REGION_W'(TOTAL_PAGES))
                            end_page = REGION_W'(TOTAL_PAGES);
                        for (page = first_page; page < end_page; page++)
                            map_words[page / WORD_BITS][page % WORD_BITS] = 1'b0;
                    end
                end
                OP_ALLOC: begin
                    // First fit: lowest clear bit of the lowest word that is not full.
                    answer = '0;
                    for (w = 0; w < MAP_WORDS && !answer.alloc_ok; w++) begin
                        if (map_words[w] != '1) begin
                            for (b = 0; b < WORD_BITS && !answer.alloc_ok; b++) begin
                                if (!map_words[w][b]) begin
                                    map_words[w][b]     = 1'b1;
                                    answer.page_address = ADDR_W'((w * WORD_BITS + b) << PAGE_SHIFT);
                                    answer.alloc_ok     = 1'b1;
                                end
                            end
                        end
                    end
                    owed_answers.push_back(answer);
                end
                default: ;
            endcase
        endfunction

        function void note_mismatch(string why, t_out_item want, t_out_item got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s: expected addr 0x%07h ok %0b, got addr 0x%07h ok %0b",
                         $time, why, want.page_address, want.alloc_ok,
                         got.page_address, got.alloc_ok);
        endfunction

        function void check_item(t_out_item got);
            t_out_item want;
            if (owed_answers.size() == 0) begin
                note_mismatch("answer with none owed", '0, got);
            end else begin
                want = owed_answers.pop_front();
                answers++;
                if (got.page_address !== want.page_address)
                    note_mismatch("page address differs", want, got);
                else if (got.alloc_ok !== want.alloc_ok)
                    note_mismatch("alloc_ok differs", want, got);
                else if (want.alloc_ok)
                    taken++;
                else
                    map_full++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_in_item          in_item   = '0;
    logic              out_stall = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [PROT_W-1:0] cfg_wdata = PROT_RESET;
    logic              in_stall;
    logic              out_valid;
    t_out_item         out_item;

    alloc_scoreboard board = new();

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int op_count [4]   = '{default: 0};
    int settings_used  = 0;
    int idle_run       = 0;

    bitmap_page_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    function automatic logic [REGION_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item make_item(logic [OPC_W-1:0] op, logic [REGION_W-1:0] base,
                                           logic [REGION_W-1:0] len, logic [TYPE_W-1:0] kind);
        t_in_item it;
        it.opcode        = op;
        it.region_base   = base;
        it.region_length = len;
        it.region_type   = kind;
        return it;
    endfunction

    // Fill, allocate and the unused code ignore the region fields: fill them with noise.
    function automatic t_in_item junk_item(logic [OPC_W-1:0] op);
        return make_item(op, rand64(), rand64(), $urandom);
    endfunction

    // About half are page-aligned usable regions inside the map; the rest stray outside it,
    // carry odd offsets, huge lengths or a type that frees nothing.
    function automatic t_in_item random_free();
        t_in_item it;
        int       pick;
        pick = $urandom_range(99);
        it   = make_item(OP_FREE,
                         REGION_W'($urandom_range(0, TOTAL_PAGES - 1)) << PAGE_SHIFT,
                         REGION_W'($urandom_range(0, 400)) << PAGE_SHIFT,
                         USABLE_TYPE);
        if (pick < 25) begin
            it.region_base[PAGE_SHIFT-1:0]   = PAGE_SHIFT'($urandom);
            it.region_length[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
        end else if (pick < 35) begin
            it.region_base   = rand64();
            it.region_length = rand64();
        end else if (pick < 45) begin
            it.region_type = $urandom;
        end else if (pick < 52) begin
            it.region_length = rand64();
        end else if (pick < 56) begin
            it.region_type = $urandom_range(0, 7);
        end
        return it;
    endfunction

    // Offer one item, idling first at random, and hold it until the block takes it.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_item(it);
        op_count[it.opcode]++;
    endtask

    // Drop valid, wait for every owed answer, then let a silent fill or free finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.owed_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_protected(logic [PROT_W-1:0] count);
        cfg_wdata <= count;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_protected(count);
        settings_used++;
    endtask

    // Receiver: stall at random, or hold off entirely while a long hold is pending.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Check every answer the block hands over; signals read here are pre-edge values.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_item(out_item);
    end

    // Watchdog: end the run once no handshake has happened for too long.
    initial begin
        wait (rst_n);
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("%0t: watchdog expired, %0d answers still owed",
                 $time, board.owed_answers.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int                round;
        int                pick;
        logic [PROT_W-1:0] count;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, protected count at its reset value of 256.
        // A fill comes first: the map holds nothing defined before it.
        send_item(junk_item(OP_FILL));
        send_item(junk_item(OP_ALLOC));                                // map full
        send_item(make_item(OP_FREE, '0, '1, 32'd2));                  // reserved type
        send_item(make_item(OP_FREE, '0, '1, 32'd0));
        send_item(junk_item(OP_ALLOC));
        send_item(make_item(OP_FREE, '0, REGION_W'(512) << PAGE_SHIFT, USABLE_TYPE));
        send_item(junk_item(OP_ALLOC));                                // first page above floor
        send_item(junk_item(OP_ALLOC));
        send_item(junk_item(OP_UNUSED));
        // The offsets in base and length are truncated to whole pages.
        send_item(make_item(OP_FREE, (REGION_W'(1000) << PAGE_SHIFT) + 123,
                            (REGION_W'(3) << PAGE_SHIFT) + 4095, USABLE_TYPE));
        send_item(make_item(OP_FREE, 64'hFFFF_FFFF_FFFF_F000, '1, USABLE_TYPE));
        // Region that runs past the end of the map.
        send_item(make_item(OP_FREE, REGION_W'(TOTAL_PAGES - 8) << PAGE_SHIFT,
                            REGION_W'(100) << PAGE_SHIFT, USABLE_TYPE));
        send_item(make_item(OP_FREE, REGION_W'(5000) << PAGE_SHIFT, '0, USABLE_TYPE));
        send_item(make_item(OP_FREE, '0, '1, 32'hFFFF_FFFF));
        send_item(junk_item(OP_ALLOC));
        send_item(make_item(OP_FREE, '0, '1, USABLE_TYPE));            // everything above floor
        send_item(junk_item(OP_ALLOC));
        send_item(junk_item(OP_FILL));
        // Only the top page free: the highest address comes back.
        send_item(make_item(OP_FREE, REGION_W'(TOTAL_PAGES - 1) << PAGE_SHIFT,
                            REGION_W'(1) << PAGE_SHIFT, USABLE_TYPE));
        send_item(junk_item(OP_ALLOC));
        send_item(junk_item(OP_ALLOC));

        // Back-pressure: hold the receiver off while allocates keep coming, so the
        // output register and the held answer fill up and the input stalls.
        send_item(junk_item(OP_FILL));
        send_item(make_item(OP_FREE, '0, '1, USABLE_TYPE));
        hold_left = HOLD_CYCLES;
        repeat (12) send_item(junk_item(OP_ALLOC));

        // Random rounds: each one is a fresh protected count, a fill, a usable region
        // from page zero, then a mix of frees and allocates with a little noise.
        round = 0;
        while (op_count[OP_FILL] + op_count[OP_FREE] + op_count[OP_ALLOC]
               + op_count[OP_UNUSED] < TARGET_ITEMS) begin
            wait_idle();
            pick = $urandom_range(99);
            case (round)
                0: count = '0;
                1: count = PROT_W'(TOTAL_PAGES);
                2: count = '1;
                3: count = PROT_RESET;
                default: begin
                    if (pick < 30)      count = PROT_W'($urandom_range(0, TOTAL_PAGES));
                    else if (pick < 50) count = PROT_W'($urandom);
                    else if (pick < 70) count = '0;
                    else if (pick < 80) count = 16'd1;
                    else if (pick < 90) count = PROT_W'(TOTAL_PAGES - 1);
                    else                count = PROT_RESET;
                end
            endcase
            write_protected(count);

            case (round % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 48; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 48; end
                default: begin send_gap_pct = 34; recv_stall_pct = 34; end
            endcase

            send_item(junk_item(OP_FILL));
            send_item(make_item(OP_FREE, '0, REGION_W'($urandom_range(1, 4000)) << PAGE_SHIFT,
                                USABLE_TYPE));
            repeat (ROUND_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 50)      send_item(junk_item(OP_ALLOC));
                else if (pick < 88) send_item(random_free());
                else if (pick < 93) send_item(junk_item(OP_UNUSED));
                else if (pick < 95) send_item(junk_item(OP_FILL));
                else                send_item(junk_item(OP_ALLOC));
            end
            round++;
        end

        wait_idle();
        $display("Ran %0d fills, %0d region frees and %0d allocates, plus %0d unused codes,",
                 op_count[OP_FILL], op_count[OP_FREE], op_count[OP_ALLOC], op_count[OP_UNUSED]);
        $display("over %0d protected-page settings: %0d answers, %0d pages taken, %0d map full.",
                 settings_used, board.answers, board.taken, board.map_full);
        if (board.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches in all", board.mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
